/* src/bai_pkg.sv */
package bai_pkg;

  localparam int ADDR_BITS    = 32;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 48;
  localparam int MOVE_ALIGN   = 8;

  // two spare bits hold begin + size and page rounding carries without loss
  localparam int CALC_W   = ADDR_BITS + 2;
  localparam int DATA_W   = 32;
  localparam int ALIGN_W  = 13;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 136;
  localparam int M_USED_LO = 34;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IDX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDX = 1'b1;

  localparam logic [DATA_W-1:0] MIN_BYTES_RST = 32'd4096;
  localparam logic [DATA_W-1:0] MAX_BYTES_RST = 32'd1048576;

  typedef logic [CALC_W-1:0] calc_t;

  localparam calc_t PAGE_C    = calc_t'(PAGE_BYTES);
  localparam calc_t PAGE_M1   = calc_t'(PAGE_BYTES - 1);
  localparam calc_t PAGE_MASK = ~PAGE_M1;
  localparam calc_t HDR_C     = calc_t'(HEADER_BYTES);

  localparam longint unsigned LIMIT_RST_L =
    (longint'(MAX_BYTES_RST) + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
  localparam logic [ADDR_BITS-1:0] LIMIT_RST = ADDR_BITS'(LIMIT_RST_L);
  localparam logic [ADDR_BITS-1:0] USED_RST  = ADDR_BITS'(HEADER_BYTES);
  localparam logic [ADDR_BITS-1:0] CMT_RST   = ADDR_BITS'(PAGE_BYTES);
  localparam logic [ALIGN_W-1:0]   MOVE_AM1  = ALIGN_W'(MOVE_ALIGN - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_REALLOC = 3'd2,
    CMD_STACK   = 3'd3,
    CMD_INIT    = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    calc_t sum;
    logic  borrow;
    logic  zero;
  } alu_res_t;

endpackage

/* src/bump_arena_allocator_top.sv */
// Bump arena allocator. Each request beat on the slave stream (tuser = command) runs through
// a small sequencer that drives one shared 34-bit add/subtract unit, one operation per cycle,
// and yields exactly one response beat. Steps per request, in order:
// - alloc: align the begin, add the size, fail when the end passes the limit, finish when
//   the commit covers the new end, else run the power-of-two search, one doubling per
//   cycle, and clamp the commit to the limit.
// - free: check the offset against the header and the used offset and set used to it; when
//   the commit is above the minimum and the offset is at most a quarter of it, shrink it by
//   a power-of-two search on 2 * offset, floored to the minimum commit.
// - realloc: compare offset + size with used; grow in place or move, then run the alloc steps.
// - stack carve: round the size up to pages, add a guard page, check the room, cut the limit.
// - init: round max and min to pages, check max against header and range, then min against max.
// - unknown commands: go straight to the output state.
// The last state waits while the output register still holds an unaccepted beat.
// s_axis_tready is high only while the sequencer is idle, so requests are served one at a
// time; the response sits in an output register, and the next request is taken while it
// waits. min_bytes/max_bytes take effect on the init command only.
module bump_arena_allocator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: size_bytes[31:0], new_size_bytes[63:32], align_bytes[76:64],
  //        offset[108:77], zero_fill[109], zero pad[111:110]
  input  logic [bai_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [bai_pkg::CMD_W-1:0]         s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: result_offset[31:0], copy_needed[32], zero_request[33], used_bytes[65:34],
  //        committed_bytes[97:66], available_bytes[129:98], zero pad[135:130]
  output logic [bai_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // tuser: status[1:0]
  output logic [bai_pkg::STATUS_W-1:0]      m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [bai_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bai_pkg::DATA_W-1:0]        cfg_wdata_i
);
  import bai_pkg::*;

  typedef enum logic [23:0] {
    ST_IDLE   = 24'h000001,
    ST_A_BEG  = 24'h000002,  // begin = align_up(used)
    ST_A_END  = 24'h000004,  // end = begin + size
    ST_A_LIM  = 24'h000008,  // end past limit?
    ST_A_CMT  = 24'h000010,  // end past committed?
    ST_POW    = 24'h000020,  // power-of-two search, one doubling per cycle
    ST_CAP    = 24'h000040,  // clamp to limit (alloc) or floor to minimum (free)
    ST_F_LO   = 24'h000080,
    ST_F_HI   = 24'h000100,
    ST_F_MIN  = 24'h000200,
    ST_F_QTR  = 24'h000400,
    ST_R_SUM  = 24'h000800,
    ST_R_EQ   = 24'h001000,
    ST_R_EXT  = 24'h002000,
    ST_C_RND  = 24'h004000,
    ST_C_TOT  = 24'h008000,
    ST_C_ROOM = 24'h010000,
    ST_C_CHK  = 24'h020000,
    ST_C_CUT  = 24'h040000,
    ST_I_MAX  = 24'h080000,
    ST_I_MIN  = 24'h100000,
    ST_I_HDR  = 24'h200000,
    ST_I_CHK  = 24'h400000,
    ST_OUT    = 24'h800000
  } state_e;

  state_e state_q, state_d;

  // arena state
  logic [ADDR_BITS-1:0] used_q, used_d;
  logic [ADDR_BITS-1:0] cmt_q, cmt_d;
  logic [ADDR_BITS-1:0] limit_q, limit_d;
  logic [ADDR_BITS-1:0] minc_q, minc_d;
  logic [DATA_W-1:0]    min_bytes_q, min_bytes_d;
  logic [DATA_W-1:0]    max_bytes_q, max_bytes_d;

  // working registers
  calc_t                t0_q, t0_d, t1_q, t1_d, pw_q, pw_d, sz_q, sz_d;
  logic [DATA_W-1:0]    new_q, new_d, off_q, off_d;
  logic [ALIGN_W-1:0]   am1_q, am1_d;
  logic                 aen_q, aen_d, zf_q, zf_d, copyf_q, copyf_d, keep_q, keep_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;

  // response fields
  status_e              status_q, status_d;
  logic [DATA_W-1:0]    result_q, result_d;
  logic                 copy_q, copy_d, zreq_q, zreq_d;

  // output register
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [STATUS_W-1:0]  m_user_q, m_user_d;

  // shared unit
  alu_op_e  alu_op;
  calc_t    alu_a, alu_b;
  alu_res_t alu;

  bai_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  logic [DATA_W-1:0]  in_size, in_new, in_off;
  logic [ALIGN_W-1:0] in_align;
  logic               in_zf;
  calc_t              align_mask, pow_x;
  logic [DATA_W-1:0]  avail;
  logic               is_free;

  assign in_size  = s_axis_tdata[31:0];
  assign in_new   = s_axis_tdata[63:32];
  assign in_align = s_axis_tdata[76:64];
  assign in_off   = s_axis_tdata[108:77];
  assign in_zf    = s_axis_tdata[109];

  // align-1 mask; non power-of-two alignments mask the same way
  assign align_mask = aen_q ? ~{{(CALC_W-ALIGN_W){1'b0}}, am1_q} : '1;
  assign is_free    = (cmd_q == CMD_FREE);
  assign pow_x      = is_free ? calc_t'({off_q, 1'b0}) : t1_q;
  assign avail      = alu.borrow ? '0 : alu.sum[DATA_W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    cmt_d       = cmt_q;
    limit_d     = limit_q;
    minc_d      = minc_q;
    min_bytes_d = min_bytes_q;
    max_bytes_d = max_bytes_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    pw_d        = pw_q;
    sz_d        = sz_q;
    new_d       = new_q;
    off_d       = off_q;
    am1_d       = am1_q;
    aen_d       = aen_q;
    zf_d        = zf_q;
    copyf_d     = copyf_q;
    keep_d      = keep_q;
    cmd_d       = cmd_q;
    status_d    = status_q;
    result_d    = result_q;
    copy_d      = copy_q;
    zreq_d      = zreq_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    alu_op      = ALU_SUB;
    alu_a       = '0;
    alu_b       = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_IDX: min_bytes_d = cfg_wdata_i;
        CFG_MAX_IDX: max_bytes_d = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d    = s_axis_tuser;
          sz_d     = calc_t'(in_size);
          new_d    = in_new;
          off_d    = in_off;
          am1_d    = in_align - ALIGN_W'(1);
          aen_d    = (in_align != '0);
          zf_d     = in_zf;
          copyf_d  = 1'b0;
          keep_d   = 1'b0;
          status_d = STATUS_OK;
          result_d = '0;
          copy_d   = 1'b0;
          zreq_d   = 1'b0;
          unique case (s_axis_tuser)
            CMD_ALLOC:   state_d = ST_A_BEG;
            CMD_FREE:    state_d = ST_F_LO;
            CMD_REALLOC: state_d = ST_R_SUM;
            CMD_STACK:   state_d = ST_C_RND;
            CMD_INIT:    state_d = ST_I_MAX;
            default:     state_d = ST_OUT;
          endcase
        end
      end

      ST_A_BEG: begin
        alu_op  = ALU_ADD;
        alu_a   = calc_t'(used_q);
        alu_b   = aen_q ? calc_t'(am1_q) : '0;
        t0_d    = alu.sum & align_mask;
        state_d = ST_A_END;
      end

      ST_A_END: begin
        alu_op  = ALU_ADD;
        alu_a   = t0_q;
        alu_b   = sz_q;
        t1_d    = alu.sum;
        state_d = ST_A_LIM;
      end

      ST_A_LIM: begin
        alu_a = calc_t'(limit_q);
        alu_b = t1_q;
        if (alu.borrow) begin
          status_d = STATUS_NO_SPACE;
          state_d  = ST_OUT;
        end else begin
          state_d  = ST_A_CMT;
        end
      end

      ST_A_CMT: begin
        alu_a = calc_t'(cmt_q);
        alu_b = t1_q;
        if (alu.borrow) begin
          pw_d    = calc_t'(1);
          state_d = ST_POW;
        end else begin
          used_d   = t1_q[ADDR_BITS-1:0];
          result_d = keep_q ? off_q : t0_q[DATA_W-1:0];
          copy_d   = copyf_q;
          zreq_d   = zf_q;
          state_d  = ST_OUT;
        end
      end

      ST_POW: begin
        alu_a = pw_q;
        alu_b = pow_x;
        if (alu.borrow) begin
          pw_d = pw_q << 1;
        end else begin
          state_d = ST_CAP;
        end
      end

      ST_CAP: begin
        if (is_free) begin
          // grow back up to the minimum commit
          alu_a = pw_q;
          alu_b = calc_t'(minc_q);
          cmt_d = alu.borrow ? minc_q : pw_q[ADDR_BITS-1:0];
        end else begin
          alu_a    = calc_t'(limit_q);
          alu_b    = pw_q;
          cmt_d    = alu.borrow ? limit_q : pw_q[ADDR_BITS-1:0];
          used_d   = t1_q[ADDR_BITS-1:0];
          result_d = keep_q ? off_q : t0_q[DATA_W-1:0];
          copy_d   = copyf_q;
          zreq_d   = zf_q;
        end
        state_d = ST_OUT;
      end

      ST_F_LO: begin
        alu_a = calc_t'(off_q);
        alu_b = HDR_C;
        if (alu.borrow) begin
          status_d = STATUS_BAD_FREE;
          state_d  = ST_OUT;
        end else begin
          state_d  = ST_F_HI;
        end
      end

      ST_F_HI: begin
        alu_a = calc_t'(used_q);
        alu_b = calc_t'(off_q);
        if (alu.borrow) begin
          status_d = STATUS_BAD_FREE;
          state_d  = ST_OUT;
        end else begin
          used_d   = off_q[ADDR_BITS-1:0];
          state_d  = ST_F_MIN;
        end
      end

      ST_F_MIN: begin
        alu_a   = calc_t'(minc_q);
        alu_b   = calc_t'(cmt_q);
        state_d = alu.borrow ? ST_F_QTR : ST_OUT;
      end

      ST_F_QTR: begin
        // shrink only when used <= committed / 4
        alu_a = calc_t'(cmt_q >> 2);
        alu_b = calc_t'(off_q);
        if (alu.borrow) begin
          state_d = ST_OUT;
        end else begin
          pw_d    = calc_t'(1);
          state_d = ST_POW;
        end
      end

      ST_R_SUM: begin
        alu_op  = ALU_ADD;
        alu_a   = calc_t'(off_q);
        alu_b   = sz_q;
        t0_d    = alu.sum;
        state_d = ST_R_EQ;
      end

      ST_R_EQ: begin
        alu_a = t0_q;
        alu_b = calc_t'(used_q);
        if (alu.zero) begin
          state_d = ST_R_EXT;
        end else begin
          // moved block: fresh 8-byte aligned alloc of the new size
          sz_d    = calc_t'(new_q);
          am1_d   = MOVE_AM1;
          aen_d   = 1'b1;
          copyf_d = 1'b1;
          state_d = ST_A_BEG;
        end
      end

      ST_R_EXT: begin
        alu_a   = calc_t'(new_q);
        alu_b   = sz_q;
        sz_d    = alu.borrow ? '0 : alu.sum;
        aen_d   = 1'b0;
        keep_d  = 1'b1;
        state_d = ST_A_BEG;
      end

      ST_C_RND: begin
        alu_op  = ALU_ADD;
        alu_a   = sz_q;
        alu_b   = PAGE_M1;
        t0_d    = alu.sum & PAGE_MASK;
        state_d = ST_C_TOT;
      end

      ST_C_TOT: begin
        alu_op  = ALU_ADD;
        alu_a   = t0_q;
        alu_b   = PAGE_C;
        t1_d    = alu.sum;
        state_d = ST_C_ROOM;
      end

      ST_C_ROOM: begin
        alu_a   = calc_t'(limit_q);
        alu_b   = calc_t'(used_q);
        t0_d    = alu.borrow ? '0 : alu.sum;
        state_d = ST_C_CHK;
      end

      ST_C_CHK: begin
        alu_a = t0_q;
        alu_b = t1_q;
        if (alu.borrow) begin
          status_d = STATUS_NO_SPACE;
          state_d  = ST_OUT;
        end else begin
          state_d  = ST_C_CUT;
        end
      end

      ST_C_CUT: begin
        alu_a    = calc_t'(limit_q);
        alu_b    = t1_q;
        result_d = DATA_W'(limit_q);
        limit_d  = alu.sum[ADDR_BITS-1:0];
        state_d  = ST_OUT;
      end

      ST_I_MAX: begin
        alu_op  = ALU_ADD;
        alu_a   = calc_t'(max_bytes_q);
        alu_b   = PAGE_M1;
        t0_d    = alu.sum & PAGE_MASK;
        state_d = ST_I_MIN;
      end

      ST_I_MIN: begin
        // zero minimum means one page
        alu_op  = ALU_ADD;
        alu_a   = (min_bytes_q == '0) ? PAGE_C : calc_t'(min_bytes_q);
        alu_b   = PAGE_M1;
        t1_d    = alu.sum & PAGE_MASK;
        state_d = ST_I_HDR;
      end

      ST_I_HDR: begin
        alu_a = t0_q;
        alu_b = HDR_C;
        if (alu.borrow || (t0_q == '0) || (t0_q[CALC_W-1:ADDR_BITS] != '0)) begin
          status_d = STATUS_NO_SPACE;
          state_d  = ST_OUT;
        end else begin
          state_d  = ST_I_CHK;
        end
      end

      ST_I_CHK: begin
        alu_a = t0_q;
        alu_b = t1_q;
        if (alu.borrow) begin
          status_d = STATUS_NO_SPACE;
        end else begin
          used_d  = USED_RST;
          cmt_d   = t1_q[ADDR_BITS-1:0];
          minc_d  = t1_q[ADDR_BITS-1:0];
          limit_d = t0_q[ADDR_BITS-1:0];
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        alu_a = calc_t'(limit_q);
        alu_b = calc_t'(used_q);
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{(M_TDATA_W-4*DATA_W-2){1'b0}}, avail, DATA_W'(cmt_q),
                       DATA_W'(used_q), zreq_q, copy_q, result_q};
          m_user_d  = status_q;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= USED_RST;
      cmt_q       <= CMT_RST;
      limit_q     <= LIMIT_RST;
      minc_q      <= CMT_RST;
      min_bytes_q <= MIN_BYTES_RST;
      max_bytes_q <= MAX_BYTES_RST;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      cmt_q       <= cmt_d;
      limit_q     <= limit_d;
      minc_q      <= minc_d;
      min_bytes_q <= min_bytes_d;
      max_bytes_q <= max_bytes_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q     <= t0_d;
    t1_q     <= t1_d;
    pw_q     <= pw_d;
    sz_q     <= sz_d;
    new_q    <= new_d;
    off_q    <= off_d;
    am1_q    <= am1_d;
    aen_q    <= aen_d;
    zf_q     <= zf_d;
    copyf_q  <= copyf_d;
    keep_q   <= keep_d;
    cmd_q    <= cmd_d;
    status_q <= status_d;
    result_q <= result_d;
    copy_q   <= copy_d;
    zreq_q   <= zreq_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

endmodule

/* src/bai_alu.sv */
module bai_alu (
  input  bai_pkg::alu_op_e  op_i,
  input  bai_pkg::calc_t    a_i,
  input  bai_pkg::calc_t    b_i,
  output bai_pkg::alu_res_t res_o
);
  import bai_pkg::*;

  logic [CALC_W:0] diff;

  assign diff = {1'b0, a_i} - {1'b0, b_i};

  always_comb begin
    res_o = '0;
    case (op_i)
      ALU_ADD: begin
        res_o.sum = a_i + b_i;
      end
      default: begin
        res_o.sum    = diff[CALC_W-1:0];
        res_o.borrow = diff[CALC_W];
      end
    endcase
    res_o.zero = (res_o.sum == '0);
  end

endmodule

/* src/bai_checker.sv */
module bai_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bai_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [bai_pkg::STATUS_W-1:0]  m_axis_tuser
);
  import bai_pkg::*;

  // sequencer is busy on the cycle after any accepted request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while sequencer busy");

  // a stalled response holds
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled response changed");

  // failures report no block, no copy and no zero request
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> m_axis_tdata[M_USED_LO-1:0] == '0)
    else $error("failed request returned a block");

  // used offset never drops into the header
  a_used_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[M_USED_LO+DATA_W-1:M_USED_LO] >= DATA_W'(HEADER_BYTES))
    else $error("used offset below header");

endmodule

bind bump_arena_allocator_top bai_checker u_bai_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/bump_arena_allocator_checker.sv */
`timescale 1ns / 1ps
module bump_arena_allocator_checker
  import bai_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // size_bytes, new_size_bytes, align_bytes, offset, zero_fill
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  // cmd
  input  logic [CMD_W-1:0]     s_tuser_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // result_offset, copy_needed, zero_request, used, committed, available
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  // status
  input  logic [STATUS_W-1:0]  m_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  output logic [31:0]          arena_used_o,
  output int                   resp_pending_o,
  output int                   fail_count_o
);

  typedef logic [63:0] wide_t;

  typedef struct {
    status_e     status;
    logic [31:0] offset;
    logic        copy;
    logic        zero;
    logic [31:0] used;
    logic [31:0] committed;
    logic [31:0] avail;
  } arena_resp_t;

  localparam wide_t PAGE_W = wide_t'(PAGE_BYTES);
  localparam wide_t HDR_W  = wide_t'(HEADER_BYTES);
  localparam wide_t ADDR_M = (wide_t'(1) << ADDR_BITS) - 1;

  // shadow of the arena bookkeeping, kept wide so sums never wrap
  wide_t       used_q, cmt_q, limit_q, resv_q, min_cmt_q;
  logic [31:0] min_reg_q, max_reg_q;
  arena_resp_t resp_due_q[$];
  int          fails = 0;

  assign fail_count_o = fails;

  function automatic wide_t page_round(wide_t x);
    return (x + PAGE_W - 1) / PAGE_W * PAGE_W;
  endfunction

  function automatic wide_t pow2_ceil(wide_t x);
    wide_t p = 1;
    while (p < x && p < (wide_t'(1) << 62)) p = p << 1;
    return p;
  endfunction

  // bump the used offset; grows the commit on success
  function automatic logic bump(wide_t size, wide_t align, output wide_t blk_start);
    wide_t start, stop, cap;
    start = used_q;
    if (align != 0) start = (used_q + align - 1) & ~(align - 1);
    stop = start + size;
    blk_start = start;
    if (stop > limit_q) return 1'b0;
    if (stop > cmt_q) begin
      cap = pow2_ceil(stop);
      cmt_q = (cap > limit_q) ? limit_q : cap;
    end
    used_q = stop;
    return 1'b1;
  endfunction

  function automatic arena_resp_t serve_request(logic [CMD_W-1:0] cmd, wide_t size,
                                                wide_t nsize, wide_t align, wide_t off,
                                                logic zf);
    arena_resp_t r;
    wide_t       blk, sz, room, mx, mn, extra, avail;
    r.status = STATUS_OK;
    r.offset = '0;
    r.copy   = 1'b0;
    r.zero   = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        if (bump(size, align, blk)) begin
          r.offset = blk[31:0];
          r.zero   = zf;
        end else begin
          r.status = STATUS_NO_SPACE;
        end
      end
      CMD_FREE: begin
        if (off < HDR_W || off > used_q) begin
          r.status = STATUS_BAD_FREE;
        end else begin
          used_q = off;
          if (cmt_q > min_cmt_q && used_q <= (cmt_q >> 2)) begin
            blk = pow2_ceil(used_q << 1);
            cmt_q = (blk < min_cmt_q) ? min_cmt_q : blk;
          end
        end
      end
      CMD_REALLOC: begin
        if (off + size == used_q) begin
          extra = (nsize > size) ? nsize - size : 0;
          if (bump(extra, 0, blk)) begin
            r.offset = off[31:0];
            r.zero   = zf;
          end else begin
            r.status = STATUS_NO_SPACE;
          end
        end else if (bump(nsize, wide_t'(MOVE_ALIGN), blk)) begin
          r.offset = blk[31:0];
          r.copy   = 1'b1;
          r.zero   = zf;
        end else begin
          r.status = STATUS_NO_SPACE;
        end
      end
      CMD_STACK: begin
        sz = page_round(size);
        room = (limit_q >= used_q) ? limit_q - used_q : 0;
        if (room < sz + PAGE_W) begin
          r.status = STATUS_NO_SPACE;
        end else begin
          r.offset = limit_q[31:0];
          limit_q = limit_q - (sz + PAGE_W);
        end
      end
      CMD_INIT: begin
        mx = page_round(wide_t'(max_reg_q));
        mn = (min_reg_q != 0) ? page_round(wide_t'(min_reg_q)) : PAGE_W;
        if (mx == 0 || mx < HDR_W || mx > ADDR_M || mn > mx) begin
          r.status = STATUS_NO_SPACE;
        end else begin
          used_q    = HDR_W;
          cmt_q     = mn;
          min_cmt_q = mn;
          limit_q   = mx;
          resv_q    = mx;
        end
      end
      default: ;
    endcase
    avail       = (limit_q >= used_q) ? limit_q - used_q : 0;
    r.used      = used_q[31:0];
    r.committed = cmt_q[31:0];
    r.avail     = avail[31:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    arena_resp_t want;
    if (!rst_ni) begin
      used_q    = HDR_W;
      cmt_q     = PAGE_W;
      limit_q   = page_round(wide_t'(MAX_BYTES_RST));
      resv_q    = limit_q;
      min_cmt_q = PAGE_W;
      min_reg_q = MIN_BYTES_RST;
      max_reg_q = MAX_BYTES_RST;
      resp_due_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MIN_IDX) min_reg_q = cfg_wdata_i;
        else max_reg_q = cfg_wdata_i;
      end
      // response side first: a response always belongs to an older request
      if (m_tvalid_i && m_tready_i) begin
        if (resp_due_q.size() == 0) begin
          $display("%0t: response beat with none expected, expected none, actual %0h",
                   $time, m_tdata_i);
          fails++;
        end else begin
          want = resp_due_q.pop_front();
          check_field("status", 32'(want.status), 32'(m_tuser_i));
          check_field("result_offset", want.offset, m_tdata_i[31:0]);
          check_field("copy_needed", 32'(want.copy), 32'(m_tdata_i[32]));
          check_field("zero_request", 32'(want.zero), 32'(m_tdata_i[33]));
          check_field("used_bytes", want.used, m_tdata_i[M_USED_LO +: 32]);
          check_field("committed_bytes", want.committed, m_tdata_i[M_USED_LO + 32 +: 32]);
          check_field("available_bytes", want.avail, m_tdata_i[M_USED_LO + 64 +: 32]);
        end
      end
      if (s_tvalid_i && s_tready_i)
        resp_due_q.push_back(serve_request(s_tuser_i, wide_t'(s_tdata_i[31:0]),
                                           wide_t'(s_tdata_i[63:32]),
                                           wide_t'(s_tdata_i[76:64]),
                                           wide_t'(s_tdata_i[108:77]), s_tdata_i[109]));
    end
    arena_used_o   = used_q[31:0];
    resp_pending_o = resp_due_q.size();
  end

endmodule

/* tb/bump_arena_allocator_top_tb.sv */
`timescale 1ns / 1ps
module bump_arena_allocator_top_tb;
  import bai_pkg::*;

  // Cycles with no beat on either stream (and no register write) before giving up.
  // Slowest request is a realloc that grows in place and walks the full power-of-two
  // search, plus random stalls on both sides and the drain at the end.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 64;
  localparam int N_PHASES       = 8;

  // command codes the block answers with OK and no change
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [31:0]        size;
    logic [31:0]        nsize;
    logic [ALIGN_W-1:0] align;
    logic [31:0]        off;
    logic               zf;
  } arena_req_t;

  // Register settings per phase: reset values, a zero max (init fails), a one-page
  // arena, a huge fixed commit, init failures (max beyond the address range, min
  // above max), a mid-size arena and a huge arena with the smallest commit.
  logic [31:0] phase_min  [N_PHASES] = '{32'd4096, 32'd0, 32'd1, 32'hFFFF_F000,
                                         32'hFFFF_FFFF, 32'd5000, 32'h0001_0000, 32'd0};
  logic [31:0] phase_max  [N_PHASES] = '{32'd1048576, 32'd0, 32'd1, 32'hFFFF_F000,
                                         32'hFFFF_FFFF, 32'd20, 32'h0004_0000,
                                         32'hFFFF_F000};
  int          phase_items[N_PHASES] = '{180, 120, 150, 160, 80, 80, 220, 240};
  // phase 3 runs with both sides idle-free
  logic        phase_flat [N_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

  logic                 clk_i;
  logic                 rst_ni;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [CMD_W-1:0]     s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_wdata_i;

  logic [31:0] arena_used;
  int          resp_pending;
  int          fail_count;
  int          stall_cycles;
  logic        no_gaps;

  bump_arena_allocator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bump_arena_allocator_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .arena_used_o   (arena_used),
    .resp_pending_o (resp_pending),
    .fail_count_o   (fail_count)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Response side: drop tready about a third of the time unless in a flat stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (no_gaps || $urandom_range(99) >= 34);
  end

  // Watchdog: any beat or register write restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("bump_arena_allocator_top_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic arena_req_t mk(logic [CMD_W-1:0] cmd, logic [31:0] size,
                                    logic [31:0] nsize, logic [ALIGN_W-1:0] align,
                                    logic [31:0] off, logic zf);
    arena_req_t r;
    r.cmd   = cmd;
    r.size  = size;
    r.nsize = nsize;
    r.align = align;
    r.off   = off;
    r.zf    = zf;
    return r;
  endfunction

  // mostly small sizes, some medium, a few anywhere in 32 bits
  function automatic logic [31:0] pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(256);
    if (k < 90) return $urandom_range(65536);
    return $urandom();
  endfunction

  // Random request shaped around the current used offset so that frees land in
  // range and reallocs of the last block grow in place most of the time.
  function automatic arena_req_t random_request(logic [31:0] used);
    arena_req_t  r;
    int          pick;
    int          k;
    logic [31:0] span;
    // fields a command ignores still carry noise
    r = mk(CMD_ALLOC, $urandom(), $urandom(), ALIGN_W'($urandom_range(8191)), $urandom(),
           1'($urandom_range(1)));
    pick = $urandom_range(99);
    k    = $urandom_range(99);
    if (pick < 34) begin
      r.cmd  = CMD_ALLOC;
      r.size = pick_size();
      if (k < 20) r.align = '0;
      else if (k < 85) r.align = ALIGN_W'(1) << $urandom_range(12);
    end else if (pick < 55) begin
      r.cmd = CMD_FREE;
      if (k < 10) r.off = HEADER_BYTES;
      else if (k < 85) r.off = $urandom_range(used, HEADER_BYTES);
      else if (k < 92) r.off = $urandom_range(HEADER_BYTES - 1);
      else r.off = used + 1 + $urandom_range(4096);
    end else if (pick < 77) begin
      r.cmd = CMD_REALLOC;
      if (k < 60) begin
        // last block: ends exactly at the used offset
        span   = (used - HEADER_BYTES > 4096) ? 4096 : used - HEADER_BYTES;
        r.size = $urandom_range(span);
        r.off  = used - r.size;
        if ($urandom_range(99) < 80) r.nsize = r.size + $urandom_range(1024);
        else r.nsize = $urandom_range(r.size);
      end else begin
        r.size  = $urandom_range(512);
        r.nsize = pick_size();
        if (k < 80) r.off = $urandom_range(used, HEADER_BYTES);
      end
    end else if (pick < 89) begin
      r.cmd  = CMD_STACK;
      r.size = (k < 85) ? $urandom_range(20000) : $urandom();
    end else if (pick < 94) begin
      r.cmd = CMD_INIT;
    end else begin
      r.cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // tvalid drops between beats; meanwhile the next request is built from the
  // up-to-date used offset, while the block is still busy with this one.
  task automatic send_req(arena_req_t r);
    while (!no_gaps && $urandom_range(99) < 34) @(negedge clk_i);
    @(posedge clk_i);
    s_axis_tdata  <= {2'b00, r.zf, r.off, r.align, r.nsize, r.size};
    s_axis_tuser  <= r.cmd;
    s_axis_tvalid <= 1'b1;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait until every issued request has been answered
  task automatic settle();
    while (resp_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [31:0] min_v, logic [31:0] max_v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MIN_IDX;
    cfg_wdata_i <= min_v;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAX_IDX;
    cfg_wdata_i <= max_v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_ALLOC;
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_MIN_IDX;
    cfg_wdata_i   <= '0;
    no_gaps       =  1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < N_PHASES; p++) begin
      no_gaps = phase_flat[p];
      settle();
      write_cfg(phase_min[p], phase_max[p]);
      send_req(mk(CMD_INIT, '0, '0, '0, '0, 1'b0));

      if (p == 0) begin
        // zero size, power-of-two, widest and odd alignments
        send_req(mk(CMD_ALLOC, 32'd0, '0, '0, '0, 1'b1));
        send_req(mk(CMD_ALLOC, 32'd100, '0, 13'd16, '0, 1'b1));
        send_req(mk(CMD_ALLOC, 32'd1, '0, 13'd4096, '0, 1'b0));
        send_req(mk(CMD_ALLOC, 32'd5, '0, 13'd3, '0, 1'b1));
        send_req(mk(CMD_ALLOC, 32'd7, '1, 13'd8191, '1, 1'b0));
        send_req(mk(CMD_ALLOC, 32'hFFFF_FFFF, '0, 13'd4096, '0, 1'b1));
        // end past the committed size: commit doubles up
        send_req(mk(CMD_ALLOC, 32'd6000, '0, '0, '0, 1'b0));
        // realloc of the last block, growing and then not growing
        send_req(mk(CMD_REALLOC, 32'd6000, 32'd9000, '0, arena_used - 32'd6000, 1'b1));
        send_req(mk(CMD_REALLOC, 32'd9000, 32'd100, '0, arena_used - 32'd9000, 1'b1));
        // realloc of an older block moves it; also with a smaller and a huge size
        send_req(mk(CMD_REALLOC, 32'd10, 32'd300, '1, HEADER_BYTES, 1'b1));
        send_req(mk(CMD_REALLOC, 32'd500, 32'd0, '0, HEADER_BYTES, 1'b1));
        send_req(mk(CMD_REALLOC, 32'd1, 32'hFFFF_FFFF, '0, HEADER_BYTES, 1'b0));
        // frees below the header, past the used offset, at the used offset, to the header
        send_req(mk(CMD_FREE, '0, '0, '0, HEADER_BYTES - 1, 1'b0));
        send_req(mk(CMD_FREE, '0, '0, '0, arena_used + 32'd1, 1'b0));
        send_req(mk(CMD_FREE, '1, '1, '1, 32'hFFFF_FFFF, 1'b1));
        send_req(mk(CMD_FREE, '0, '0, '0, arena_used, 1'b0));
        send_req(mk(CMD_FREE, '0, '0, '0, HEADER_BYTES, 1'b0));
        // stacks: empty, one byte, too big
        send_req(mk(CMD_STACK, 32'd0, '0, '0, '0, 1'b1));
        send_req(mk(CMD_STACK, 32'd1, '0, '0, '0, 1'b0));
        send_req(mk(CMD_STACK, 32'hFFFF_FFFF, '0, '0, '0, 1'b0));
        // spare command codes
        send_req(mk(CMD_SPARE_LO, '1, '1, '1, '1, 1'b1));
        send_req(mk(CMD_SPARE_HI, '1, '1, '1, '1, 1'b1));
        send_req(mk(CMD_INIT, '1, '1, '1, '1, 1'b1));
        send_req(mk(CMD_ALLOC, 32'd0, '1, '0, '1, 1'b1));
        // free at minimum commit: no shrink
        send_req(mk(CMD_FREE, '0, '0, '0, HEADER_BYTES, 1'b0));
      end

      repeat (phase_items[p]) send_req(random_request(arena_used));
    end

    no_gaps = 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bump_arena_allocator_top_tb OK");
    end else begin
      $display("bump_arena_allocator_top_tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
src/bai_pkg.sv
src/bai_alu.sv
src/bump_arena_allocator_top.sv
src/bai_checker.sv
tb/bump_arena_allocator_checker.sv
tb/bump_arena_allocator_top_tb.sv
